>>> hw/rtl/dmpe_pkg.sv
// ----------------------------------------------------------------------------
// dmpe_pkg
// Shared constants, command codes and controller/datapath structs for the
// digit matrix permute engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmpe_pkg;

    localparam int MAX_SIZE_DEF = 16;

    localparam int CFG_W   = 5;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 4;
    localparam int DIGIT_W = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
    localparam logic [DIGIT_W-1:0] DIGIT_TOP = DIGIT_W'(9);

    // command kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TRANS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ROWS  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COLS  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INC   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEC   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd6;

    // RAM write data select
    localparam logic [1:0] WD_DIGIT = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_HOLD  = 2'd2;
    localparam logic [1:0] WD_STEP  = 2'd3;

    typedef struct packed {
        logic              ram_rd;
        logic              ram_wr;
        logic              addr_q;     // address the second cell of a pair
        logic [1:0]        wd_sel;
        logic              hold_load;
        logic              out_load;
        logic [KIND_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] side;        // side in use, clipped to the store
        logic             in_ok;       // both incoming indices in range
        logic             in_neq;      // incoming indices differ
        logic             out_free;    // result register can take an item
    } t_dp_stat;

endpackage

>>> hw/rtl/dmpe_ram.sv
// ----------------------------------------------------------------------------
// dmpe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmpe_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/dmpe_datapath.sv
// ----------------------------------------------------------------------------
// dmpe_datapath
// Cell store, address generation, digit arithmetic, size register and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmpe_datapath #(
    parameter int MAX_SIZE = dmpe_pkg::MAX_SIZE_DEF,
    parameter int CNT_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [dmpe_pkg::IDX_W-1:0]   i_index_a,
    input  logic [dmpe_pkg::IDX_W-1:0]   i_index_b,
    input  logic [dmpe_pkg::DIGIT_W-1:0] i_digit,
    input  logic                         i_cfg_wr_en,
    input  logic [dmpe_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  dmpe_pkg::t_dp_cmd            i_cmd,
    input  logic [CNT_W-1:0]             i_row,
    input  logic [CNT_W-1:0]             i_col,
    input  logic                         i_out_ready,
    output dmpe_pkg::t_dp_stat           o_stat,
    output logic                         o_out_valid,
    output logic [dmpe_pkg::DIGIT_W-1:0] o_cell_digit,
    output logic                         o_bad_index
);
    import dmpe_pkg::*;

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0]   r_cfg;
    logic [IDX_W-1:0]   r_a;
    logic [IDX_W-1:0]   r_b;
    logic [DIGIT_W-1:0] r_digit;
    logic               r_ok;
    logic [DIGIT_W-1:0] r_hold;
    logic               r_out_valid;
    logic [DIGIT_W-1:0] r_out_digit;
    logic               r_out_bad;

    logic [CFG_W-1:0]   side;
    logic [AW-1:0]      addr_p;
    logic [AW-1:0]      addr_q;
    logic [AW-1:0]      addr;
    logic [DIGIT_W-1:0] rd_data;
    logic [DIGIT_W-1:0] wr_data;
    logic [DIGIT_W-1:0] step_data;
    logic [CNT_W-1:0]   ra;
    logic [CNT_W-1:0]   rb;

    function automatic logic [AW-1:0] cell_addr(input logic [CNT_W-1:0] row,
                                                input logic [CNT_W-1:0] col);
        cell_addr = AW'(row) * AW'(MAX_SIZE) + AW'(col);
    endfunction

    // a matrix_size above the store acts as the store side
    assign side = (32'(r_cfg) > MAX_SIZE) ? CFG_W'(MAX_SIZE) : r_cfg;

    assign o_stat.side     = side;
    assign o_stat.in_ok    = ({1'b0, i_index_a} < side) && ({1'b0, i_index_b} < side);
    assign o_stat.in_neq   = (i_index_a != i_index_b);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a     <= i_index_a;
            r_b     <= i_index_b;
            r_digit <= (i_digit > DIGIT_TOP) ? DIGIT_TOP : i_digit;
            r_ok    <= o_stat.in_ok;
        end
        if (i_cmd.hold_load) begin
            r_hold <= rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_digit <= r_ok ? rd_data : '0;
            r_out_bad   <= !r_ok;
        end
    end

    // indices are only used in range, so narrowing to the counter width is safe
    assign ra = CNT_W'(r_a);
    assign rb = CNT_W'(r_b);

    always_comb begin
        case (i_cmd.op)
            KIND_TRANS: begin
                addr_p = cell_addr(i_row, i_col);
                addr_q = cell_addr(i_col, i_row);
            end
            KIND_ROWS: begin
                addr_p = cell_addr(ra, i_col);
                addr_q = cell_addr(rb, i_col);
            end
            KIND_COLS: begin
                addr_p = cell_addr(i_row, ra);
                addr_q = cell_addr(i_row, rb);
            end
            KIND_INC, KIND_DEC: begin
                addr_p = cell_addr(i_row, i_col);
                addr_q = addr_p;
            end
            default: begin
                addr_p = cell_addr(ra, rb);
                addr_q = addr_p;
            end
        endcase
    end

    assign addr = i_cmd.addr_q ? addr_q : addr_p;

    always_comb begin
        if (i_cmd.op == KIND_DEC) begin
            step_data = (rd_data == '0) ? DIGIT_TOP : rd_data - DIGIT_W'(1);
        end else begin
            step_data = (rd_data >= DIGIT_TOP) ? '0 : rd_data + DIGIT_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.wd_sel)
            WD_DIGIT: wr_data = r_digit;
            WD_RDATA: wr_data = rd_data;
            WD_HOLD:  wr_data = r_hold;
            WD_STEP:  wr_data = step_data;
            default:  wr_data = r_digit;
        endcase
    end

    dmpe_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ram_wr),
        .i_wr_addr (addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid  = r_out_valid;
    assign o_cell_digit = r_out_digit;
    assign o_bad_index  = r_out_bad;

`ifndef SYNTHESIS
    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_digit == '0))
        else $error("bad-index result carries a non-zero digit");

    // cells never written hold unknown data, which the step passes on as it is
    a_wr_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ram_wr && (i_cmd.wd_sel == WD_DIGIT ||
                          (i_cmd.wd_sel == WD_STEP && !$isunknown(rd_data))))
        |-> (wr_data <= DIGIT_TOP))
        else $error("digit written to the store is above nine");
`endif

endmodule

>>> hw/rtl/dmpe_ctrl.sv
// ----------------------------------------------------------------------------
// dmpe_ctrl
// Command sequencer: walks cells and cell pairs of the store for each
// command and drives the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmpe_ctrl #(
    parameter int MAX_SIZE = dmpe_pkg::MAX_SIZE_DEF,
    parameter int CNT_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [dmpe_pkg::KIND_W-1:0] i_kind,
    input  dmpe_pkg::t_dp_stat          i_stat,
    output logic                        o_in_ready,
    output dmpe_pkg::t_dp_cmd           o_cmd,
    output logic [CNT_W-1:0]            o_row,
    output logic [CNT_W-1:0]            o_col
);
    import dmpe_pkg::*;

    localparam int CMP_W = (CNT_W + 2 > CFG_W) ? CNT_W + 2 : CFG_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WR_CELL  = 4'd1;
    localparam logic [3:0] S_RD_ISSUE = 4'd2;
    localparam logic [3:0] S_RD_DATA  = 4'd3;
    localparam logic [3:0] S_SW_RD_P  = 4'd4;
    localparam logic [3:0] S_SW_RD_Q  = 4'd5;
    localparam logic [3:0] S_SW_WR_P  = 4'd6;
    localparam logic [3:0] S_SW_WR_Q  = 4'd7;
    localparam logic [3:0] S_RMW_RD   = 4'd8;
    localparam logic [3:0] S_RMW_WR   = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;

    logic             accept;
    logic [CMP_W-1:0] ie, je, sw;
    logic             j_more, i_more, i_more2;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign ie      = CMP_W'(r_i);
    assign je      = CMP_W'(r_j);
    assign sw      = CMP_W'(i_stat.side);
    assign j_more  = (je + CMP_W'(1)) < sw;
    assign i_more  = (ie + CMP_W'(1)) < sw;
    assign i_more2 = (ie + CMP_W'(2)) < sw;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_i     = r_i;
        n_j     = r_j;

        o_cmd           = '0;
        o_cmd.op        = r_kind;
        o_cmd.wd_sel    = WD_DIGIT;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_kind;
                    n_i    = '0;
                    n_j    = '0;
                    case (i_kind)
                        KIND_WRITE: begin
                            if (i_stat.in_ok) n_state = S_WR_CELL;
                        end
                        KIND_TRANS: begin
                            if (i_stat.side >= CFG_W'(2)) begin
                                n_state = S_SW_RD_P;
                                n_j     = CNT_W'(1);
                            end
                        end
                        KIND_ROWS, KIND_COLS: begin
                            if (i_stat.in_ok && i_stat.in_neq) n_state = S_SW_RD_P;
                        end
                        KIND_INC, KIND_DEC: begin
                            if (i_stat.side != '0) n_state = S_RMW_RD;
                        end
                        KIND_READ: n_state = S_RD_ISSUE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_WR_CELL: begin
                o_cmd.ram_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD_ISSUE: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_RD_DATA;
            end
            S_RD_DATA: begin
                // store data waits in the RAM output until the result slot frees
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SW_RD_P: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_SW_RD_Q;
            end
            S_SW_RD_Q: begin
                o_cmd.ram_rd    = 1'b1;
                o_cmd.addr_q    = 1'b1;
                o_cmd.hold_load = 1'b1;
                n_state         = S_SW_WR_P;
            end
            S_SW_WR_P: begin
                o_cmd.ram_wr = 1'b1;
                o_cmd.wd_sel = WD_RDATA;
                n_state      = S_SW_WR_Q;
            end
            S_SW_WR_Q: begin
                o_cmd.ram_wr = 1'b1;
                o_cmd.addr_q = 1'b1;
                o_cmd.wd_sel = WD_HOLD;
                n_state      = S_SW_RD_P;
                case (r_kind)
                    KIND_TRANS: begin
                        // upper triangle only
                        if (j_more) begin
                            n_j = r_j + CNT_W'(1);
                        end else if (i_more2) begin
                            n_i = r_i + CNT_W'(1);
                            n_j = CNT_W'(ie + CMP_W'(2));
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    KIND_ROWS: begin
                        if (j_more) n_j = r_j + CNT_W'(1);
                        else        n_state = S_IDLE;
                    end
                    KIND_COLS: begin
                        if (i_more) n_i = r_i + CNT_W'(1);
                        else        n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RMW_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.ram_wr = 1'b1;
                o_cmd.wd_sel = WD_STEP;
                n_state      = S_RMW_RD;
                if (j_more) begin
                    n_j = r_j + CNT_W'(1);
                end else if (i_more) begin
                    n_i = r_i + CNT_W'(1);
                    n_j = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_WRITE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_row = r_i;
    assign o_col = r_j;

`ifndef SYNTHESIS
    a_bad_write_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_WRITE && !i_stat.in_ok) |=> !o_cmd.ram_wr)
        else $error("out-of-range write reached the store");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over an untaken item");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RD_Q) |=> (r_state == S_SW_WR_P && $past(o_cmd.hold_load)))
        else $error("swap sequence broken after second read");

    a_transpose_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RD_P && r_kind == KIND_TRANS) |-> (r_j > r_i))
        else $error("transpose visited a cell on or below the diagonal");
`endif

endmodule

>>> hw/rtl/digit_matrix_permute_engine.sv
// A write stores its cell; a read issues the store read, then loads the result register
// once it is free; row/column swaps, transpose and increment/decrement step through
// their cells by store reads and writes. Throughput: one item at a time; the read and
// write ports of the cell store share one address, one cell access per cycle. A result
// may wait while the next item is taken. Reset: control state and result valid clear,
// matrix_size goes to 16; the store is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// digit_matrix_permute_engine
// Square matrix of decimal digits with write, transpose, row/column swap,
// increment, decrement and read commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module digit_matrix_permute_engine #(
    parameter int MAX_SIZE = dmpe_pkg::MAX_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [dmpe_pkg::CFG_W-1:0] i_cfg_wr_data,  // matrix_size
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,   // index_a[3:0], index_b[7:4], digit[11:8]
    input  logic [2:0]                s_axis_tuser,   // kind[2:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // cell_digit[3:0]
    output logic [0:0]                m_axis_tuser    // bad_index[0]
);
    import dmpe_pkg::*;

    localparam int CNT_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [CNT_W-1:0]   row;
    logic [CNT_W-1:0]   col;
    logic [DIGIT_W-1:0] cell_digit;
    logic               bad_index;
    logic               in_load;

    assign in_load = s_axis_tvalid && s_axis_tready;

    dmpe_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser[KIND_W-1:0]),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .o_row      (row),
        .o_col      (col)
    );

    dmpe_datapath #(
        .MAX_SIZE (MAX_SIZE),
        .CNT_W    (CNT_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_load),
        .i_index_a     (s_axis_tdata[3:0]),
        .i_index_b     (s_axis_tdata[7:4]),
        .i_digit       (s_axis_tdata[11:8]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_row         (row),
        .i_col         (col),
        .i_out_ready   (m_axis_tready),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .o_cell_digit  (cell_digit),
        .o_bad_index   (bad_index)
    );

    assign m_axis_tdata = {4'b0000, cell_digit};
    assign m_axis_tuser = bad_index;

endmodule
